// ===== sv/sqvg_pkg.sv =====
// Shared types, constants and register codes of the sphere quad vertex generator.
package sqvg_pkg;

    localparam int unsigned MAX_DIVISIONS   = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned ADDR_W          = 4;
    localparam int unsigned RC_SHIFT        = 25;

    localparam logic [14:0] RADIUS_RST = 15'd4096;
    localparam logic [8:0]  COUNT_RST  = 9'd16;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_STACKS = 2'd1,
        REG_SLICES = 2'd2
    } t_reg_idx;

    // Settings seen by the datapath: counts already clamped, reciprocals floor(2^25/count).
    typedef struct packed {
        logic [14:0] radius;
        logic [8:0]  s_cnt;
        logic [8:0]  l_cnt;
        logic [25:0] s_rc;
        logic [25:0] l_rc;
    } t_cfg;

    // One quad ready for vertex generation.
    typedef struct packed {
        logic [15:0] ph0;
        logic [15:0] ph1;
        logic [15:0] th0;
        logic [15:0] th1;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_job;

    // Corner order P1 P2 P3 P1 P3 P4: bit k picks the second polar / azimuth angle.
    localparam logic [5:0] CORNER_PHI  = 6'b010110;
    localparam logic [5:0] CORNER_TH   = 6'b110100;
    localparam logic [2:0] CORNER_LAST = 3'd5;

endpackage

// ===== sv/sqvg_cfg.sv =====
// APB register file: radius and counts, clamped counts and their reciprocals.
module sqvg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqvg_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output sqvg_pkg::t_cfg                o_cfg
);
    import sqvg_pkg::*;

    logic [14:0] r_radius;
    logic [8:0]  r_stacks;
    logic [8:0]  r_slices;
    logic [8:0]  w_s_eff;
    logic [8:0]  w_l_eff;
    logic [25:0] w_rc_tab [256];
    logic        w_wr;
    t_reg_idx    w_idx;

    function automatic logic [8:0] eff_cnt(input logic [8:0] c);
        logic [8:0] v;
        if (c == 9'd0) begin
            v = 9'd1;
        end else if (c > 9'(MAX_DIVISIONS)) begin
            v = 9'(MAX_DIVISIONS);
        end else begin
            v = c;
        end
        return v;
    endfunction

    for (genvar g = 0; g < 256; g++) begin : g_rc
        localparam logic [25:0] RC = 26'((33'd1 << RC_SHIFT) / (g + 1));
        assign w_rc_tab[g] = RC;
    end

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_stacks <= COUNT_RST;
            r_slices <= COUNT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RADIUS: r_radius <= pwdata[14:0];
                REG_STACKS: r_stacks <= pwdata[8:0];
                REG_SLICES: r_slices <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RADIUS: prdata = {17'd0, r_radius};
            REG_STACKS: prdata = {23'd0, r_stacks};
            REG_SLICES: prdata = {23'd0, r_slices};
            default:    prdata = 32'd0;
        endcase
    end

    assign w_s_eff = eff_cnt(r_stacks);
    assign w_l_eff = eff_cnt(r_slices);

    assign o_cfg.radius = r_radius;
    assign o_cfg.s_cnt  = w_s_eff;
    assign o_cfg.l_cnt  = w_l_eff;
    assign o_cfg.s_rc   = w_rc_tab[8'(w_s_eff - 9'd1)];
    assign o_cfg.l_rc   = w_rc_tab[8'(w_l_eff - 9'd1)];

endmodule

// ===== sv/sqvg_front.sv =====
// Front end: accepts quad beats, derives the four angle phases and the quad colors.
module sqvg_front #(
    parameter int unsigned QUEUE_DEPTH = sqvg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [15:0]                           i_s_axis_tdata,
    input  sqvg_pkg::t_cfg                        i_cfg,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      i_q_count,
    output logic                                  o_push,
    output sqvg_pkg::t_job                        o_job
);
    import sqvg_pkg::*;

    localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUMW = CW + 3;

    localparam logic [28:0] RED_OFS   = 29'd131077;
    localparam logic [28:0] GREEN_TOP = 29'd655365;
    localparam logic [28:0] BLUE_OFS  = 29'd262154;
    localparam logic [28:0] SAT10     = 29'd655360;
    localparam logic [28:0] SAT20     = 29'd1310720;
    localparam logic [20:0] DIV10_M   = 21'd1677722;

    // Lanes 0,1: (i, i+1) * 32768 over stacks. Lanes 2,3: (j, j+1) * 65536 over slices.
    logic [6:0]  r_vld;
    logic [7:0]  r_i;
    logic [7:0]  r_j;
    logic        w_acc;
    logic [2:0]  w_inflight;
    logic [8:0]  w_k  [4];
    logic [8:0]  w_d  [4];
    logic [25:0] w_m  [4];

    logic [24:0] r_q1 [4];
    logic [8:0]  r_k1 [4];
    logic        r_gz1;
    logic [24:0] r_q2 [4];
    logic [9:0]  r_r2 [4];
    logic        r_gz2;
    logic [24:0] r_q3 [4];
    logic [7:0]  r_r3 [4];
    logic        r_gz3;
    logic [15:0] r_ph4 [4];
    logic [24:0] r_qs4;
    logic [24:0] r_ql4;
    logic [3:0]  r_f4;
    logic [2:0]  r_c4;
    logic [3:0]  r_g4;
    logic        r_gz4;
    logic [15:0] r_ph5 [4];
    logic [19:0] r_x5;
    logic [19:0] r_y5;
    logic [19:0] r_z5;
    logic        r_sr5;
    logic        r_sg5;
    logic        r_sb5;
    logic        r_gz5;
    t_job        r_job;

    logic [3:0]  w_f;
    logic [2:0]  w_c;
    logic [3:0]  w_g;
    logic [28:0] w_x;
    logic [28:0] w_y;
    logic [28:0] w_z;

    function automatic logic [15:0] div10(input logic [19:0] x);
        logic [40:0] p;
        p = 41'(x) * 41'(DIV10_M);
        return p[39:24];
    endfunction

    // Hold off new beats once queued plus in-flight quads would fill the queue.
    assign w_inflight      = 3'($countones(r_vld));
    assign o_s_axis_tready = (SUMW'(i_q_count) + SUMW'(w_inflight)) < SUMW'(QUEUE_DEPTH);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], w_acc};
        end
    end

    always_comb begin
        w_k[0] = {1'b0, r_i};
        w_k[1] = 9'(r_i) + 9'd1;
        w_k[2] = {1'b0, r_j};
        w_k[3] = 9'(r_j) + 9'd1;
        for (int l = 0; l < 4; l++) begin
            w_d[l] = (l < 2) ? i_cfg.s_cnt : i_cfg.l_cnt;
            w_m[l] = (l < 2) ? i_cfg.s_rc : i_cfg.l_rc;
        end
    end

    always_comb begin
        w_f = '0;
        w_c = '0;
        w_g = '0;
        for (int k = 1; k <= 15; k++) begin
            if (12'(k) * 12'(i_cfg.s_cnt) <= {r_r3[0], 4'd0}) begin
                w_f = w_f + 4'd1;
            end
        end
        for (int k = 1; k <= 6; k++) begin
            if (12'(k - 1) * 12'(i_cfg.l_cnt) < 12'(r_r3[2]) * 12'd6) begin
                w_c = w_c + 3'd1;
            end
        end
        for (int k = 1; k <= 9; k++) begin
            if (12'(k) * 12'(i_cfg.l_cnt) <= 12'(r_r3[2]) * 12'd10) begin
                w_g = w_g + 4'd1;
            end
        end
    end

    assign w_x = {r_qs4, 4'd0} + 29'(r_f4) + RED_OFS;
    assign w_y = GREEN_TOP - (29'(r_ql4) * 29'd6 + 29'(r_c4));
    assign w_z = 29'(r_ql4) * 29'd10 + 29'(r_g4) + BLUE_OFS;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_i <= i_s_axis_tdata[7:0];
            r_j <= i_s_axis_tdata[15:8];
        end
        // Reciprocal estimate, low by at most one.
        for (int l = 0; l < 4; l++) begin
            r_k1[l] <= w_k[l];
            if (l < 2) begin
                r_q1[l] <= 25'((35'(w_k[l]) * 35'(w_m[l])) >> (RC_SHIFT - 15));
            end else begin
                r_q1[l] <= 25'((35'(w_k[l]) * 35'(w_m[l])) >> (RC_SHIFT - 16));
            end
        end
        r_gz1 <= (11'(r_j) * 11'd3) >= (11'(i_cfg.l_cnt) * 11'd5);
        for (int l = 0; l < 4; l++) begin
            r_q2[l] <= r_q1[l];
            if (l < 2) begin
                r_r2[l] <= 10'((34'(r_k1[l]) << 15) - 34'(r_q1[l]) * 34'(w_d[l]));
            end else begin
                r_r2[l] <= 10'((34'(r_k1[l]) << 16) - 34'(r_q1[l]) * 34'(w_d[l]));
            end
        end
        r_gz2 <= r_gz1;
        // Fix up the estimate.
        for (int l = 0; l < 4; l++) begin
            if (r_r2[l] >= 10'(w_d[l])) begin
                r_q3[l] <= r_q2[l] + 25'd1;
                r_r3[l] <= 8'(r_r2[l] - 10'(w_d[l]));
            end else begin
                r_q3[l] <= r_q2[l];
                r_r3[l] <= 8'(r_r2[l]);
            end
        end
        r_gz3 <= r_gz2;
        // Round the phases half up and wrap to a 16-bit turn.
        for (int l = 0; l < 4; l++) begin
            r_ph4[l] <= 16'(r_q3[l]) +
                        16'((10'(r_r3[l]) + 10'(w_d[l] >> 1)) >= 10'(w_d[l]));
        end
        r_qs4 <= r_q3[0];
        r_ql4 <= r_q3[2];
        r_f4  <= w_f;
        r_c4  <= w_c;
        r_g4  <= w_g;
        r_gz4 <= r_gz3;
        for (int l = 0; l < 4; l++) begin
            r_ph5[l] <= r_ph4[l];
        end
        r_x5  <= 20'(w_x);
        r_y5  <= 20'(w_y);
        r_z5  <= 20'(w_z >> 1);
        r_sr5 <= w_x >= SAT10;
        r_sg5 <= w_y >= SAT10;
        r_sb5 <= w_z >= SAT20;
        r_gz5 <= r_gz4;
        r_job.ph0   <= r_ph5[0];
        r_job.ph1   <= r_ph5[1];
        r_job.th0   <= r_ph5[2];
        r_job.th1   <= r_ph5[3];
        r_job.red   <= r_sr5 ? 16'hFFFF : div10(r_x5);
        r_job.green <= r_gz5 ? 16'd0 : (r_sg5 ? 16'hFFFF : div10(r_y5));
        r_job.blue  <= r_sb5 ? 16'hFFFF : div10(r_z5);
    end

    assign o_push = r_vld[6];
    assign o_job  = r_job;

endmodule

// ===== sv/sqvg_queue.sv =====
// Short job queue between the front end and the vertex pipeline.
module sqvg_queue #(
    parameter int unsigned QUEUE_DEPTH = sqvg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  sqvg_pkg::t_job                    i_job,
    input  logic                              i_pop,
    output logic                              o_valid,
    output sqvg_pkg::t_job                    o_job,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_count
);
    import sqvg_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_wr_en;
    logic          w_rd_en;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign w_wr_en = i_push && (r_count != CW'(QUEUE_DEPTH));
    assign w_rd_en = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (w_rd_en) begin
                r_rd <= wrap_inc(r_rd);
            end
            r_count <= r_count + CW'(w_wr_en) - CW'(w_rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// ===== sv/sqvg_back.sv =====
// Vertex pipeline: walks six corners per quad, evaluates sine/cosine, scales by radius.
module sqvg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sqvg_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  sqvg_pkg::t_job  i_q_job,
    output logic            o_pop,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [95:0]     o_m_axis_tdata,
    output logic [2:0]      o_m_axis_tuser,
    output logic            o_m_axis_tlast
);
    import sqvg_pkg::*;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [2:0]  corner;
        logic        last;
    } t_side;

    // Stages: corner select, four sine steps, radius product, second product, output.
    logic [7:0]         r_vld;
    t_side              r_side [8];
    logic [2:0]         r_corner;
    logic               w_en;
    logic               w_take;
    logic [15:0]        r_p;
    logic [15:0]        r_t;
    logic [15:0]        w_ang [4];
    logic [14:0]        w_x   [4];

    logic [14:0]        r_x1  [4];
    logic [14:0]        r_xx1 [4];
    logic               r_n1  [4];
    logic [14:0]        r_x2  [4];
    logic [14:0]        r_xx2 [4];
    logic [11:0]        r_t2  [4];
    logic               r_n2  [4];
    logic [14:0]        r_x3  [4];
    logic [14:0]        r_t3  [4];
    logic               r_n3  [4];
    logic signed [17:0] r_s4  [4];
    logic signed [33:0] r_ax;
    logic signed [33:0] r_ay;
    logic signed [17:0] r_st5;
    logic signed [17:0] r_ct5;
    logic signed [51:0] r_bx;
    logic signed [51:0] r_bz;
    logic [15:0]        r_y6;
    logic [15:0]        r_xo;
    logic [15:0]        r_yo;
    logic [15:0]        r_zo;
    logic signed [15:0] w_rad;

    // Divide by 2^sh, rounding half away from zero.
    function automatic logic [15:0] rnd_shr(input logic signed [51:0] v, input int sh);
        logic [51:0] mag;
        logic [51:0] q;
        mag = (v < 0) ? 52'(-v) : 52'(v);
        q   = (mag + (52'd1 << (sh - 1))) >> sh;
        return (v < 0) ? 16'(-q) : 16'(q);
    endfunction

    assign w_en   = !r_vld[7] || i_m_axis_tready;
    assign w_take = w_en && i_q_valid;
    assign o_pop  = w_take && (r_corner == CORNER_LAST);
    assign w_rad  = $signed({1'b0, i_cfg.radius});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_corner <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[6:0], w_take};
            if (w_take) begin
                r_corner <= (r_corner == CORNER_LAST) ? 3'd0 : r_corner + 3'd1;
            end
        end
    end

    // Lanes: sin phi, cos phi, sin theta, cos theta.
    always_comb begin
        w_ang[0] = r_p;
        w_ang[1] = r_p + 16'd16384;
        w_ang[2] = r_t;
        w_ang[3] = r_t + 16'd16384;
        for (int l = 0; l < 4; l++) begin
            // Mirror the offset in odd quadrants.
            w_x[l] = w_ang[l][14] ? 15'd16384 - {1'b0, w_ang[l][13:0]}
                                  : {1'b0, w_ang[l][13:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p <= CORNER_PHI[r_corner] ? i_q_job.ph1 : i_q_job.ph0;
            r_t <= CORNER_TH[r_corner] ? i_q_job.th1 : i_q_job.th0;
            r_side[0] <= '{red: i_q_job.red, green: i_q_job.green, blue: i_q_job.blue,
                           corner: r_corner, last: r_corner == CORNER_LAST};
            for (int s = 1; s < 8; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int l = 0; l < 4; l++) begin
                r_x1[l]  <= w_x[l];
                r_xx1[l] <= 15'((30'(w_x[l]) * 30'(w_x[l])) >> 14);
                r_n1[l]  <= w_ang[l][15];
                r_x2[l]  <= r_x1[l];
                r_xx2[l] <= r_xx1[l];
                r_t2[l]  <= 12'((27'd2320 * 27'(r_xx1[l])) >> 14);
                r_n2[l]  <= r_n1[l];
                r_x3[l]  <= r_x2[l];
                r_t3[l]  <= 15'((30'(15'd21024 - 15'(r_t2[l])) * 30'(r_xx2[l])) >> 14);
                r_n3[l]  <= r_n2[l];
                r_s4[l]  <= r_n3[l]
                    ? -$signed(18'((31'(16'd51472 - 16'(r_t3[l])) * 31'(r_x3[l])) >> 14))
                    :  $signed(18'((31'(16'd51472 - 16'(r_t3[l])) * 31'(r_x3[l])) >> 14));
            end
            r_ax  <= 34'(w_rad) * 34'(r_s4[0]);
            r_ay  <= 34'(w_rad) * 34'(r_s4[1]);
            r_st5 <= r_s4[2];
            r_ct5 <= r_s4[3];
            r_bx  <= 52'(r_ax) * 52'(r_ct5);
            r_bz  <= 52'(r_ax) * 52'(r_st5);
            r_y6  <= rnd_shr(52'(r_ay), 15);
            r_xo  <= rnd_shr(r_bx, 30);
            r_yo  <= r_y6;
            r_zo  <= rnd_shr(r_bz, 30);
        end
    end

    assign o_m_axis_tvalid = r_vld[7];
    assign o_m_axis_tdata  = {r_side[7].blue, r_side[7].green, r_side[7].red,
                              r_zo, r_yo, r_xo};
    assign o_m_axis_tuser  = r_side[7].corner;
    assign o_m_axis_tlast  = r_side[7].last;

endmodule

// ===== sv/sphere_quad_vertex_generator_core.sv =====
// Top level of the sphere quad vertex generator.
//  channel   dir  beat                          fields (low bit first)
//  s_axis    in   one quad                      tdata: stack_index, slice_index
//  m_axis    out  one vertex, six per quad      tdata: x, y, z, red, green, blue;
//                                               tuser: corner_number; tlast: last_vertex
//  apb       in   register write / read         radius @0x0, stack_count @0x4, slice_count @0x8
// One vertex leaves per cycle while m_axis is ready and the queue holds a quad, through
// the single vertex pipeline (one corner select per cycle, under the same condition).
// A quad passes the front-end registers into the queue, then the vertex pipeline stages.
// Reset is synchronous; there is no clearing pass.
// A stalled output freezes the vertex pipeline; the queue keeps the front end going.
module sphere_quad_vertex_generator_core #(
    parameter int unsigned QUEUE_DEPTH = sqvg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [15:0]                  i_s_axis_tdata,   // stack_index, slice_index
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [95:0]                  o_m_axis_tdata,   // x, y, z, red, green, blue
    output logic [2:0]                   o_m_axis_tuser,   // corner_number
    output logic                         o_m_axis_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sqvg_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sqvg_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_cfg          w_cfg;
    logic          w_push;
    t_job          w_push_job;
    logic          w_pop;
    logic          w_q_valid;
    t_job          w_q_job;
    logic [CW-1:0] w_q_count;

    sqvg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sqvg_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cfg           (w_cfg),
        .i_q_count       (w_q_count),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    sqvg_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .o_count (w_q_count)
    );

    sqvg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_q_valid       (w_q_valid),
        .i_q_job         (w_q_job),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_q_count < CW'(QUEUE_DEPTH)))
        else $error("quad pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_count != '0))
        else $error("quad popped from an empty queue");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == CORNER_LAST)))
        else $error("last flag out of step with corner number");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sphere quad vertex generator core.
`timescale 1ns / 1ps

module testbench;
    import sqvg_pkg::*;

    typedef struct packed {
        logic [7:0] stack_idx;
        logic [7:0] slice_idx;
    } t_quad;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [2:0]  corner;
        logic        last;
    } t_vertex;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sphere_quad_vertex_generator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // shadow registers
    logic [14:0] sh_radius = RADIUS_RST;
    logic [8:0]  sh_stacks = COUNT_RST;
    logic [8:0]  sh_slices = COUNT_RST;

    t_quad   quad_q[$];
    t_vertex vertex_q[$];
    int      errors = 0;
    int      send_idle = 34;
    int      recv_idle = 88;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint sin_q15(input logic [15:0] phase);
        logic [1:0] quadrant;
        longint x, x2, t, s;
        quadrant = phase[15:14];
        x = phase[13:0];
        if (quadrant[0]) x = 16384 - x;
        x2 = (x * x) >>> 14;
        t = (2320 * x2) >>> 14;
        t = 21024 - t;
        t = (t * x2) >>> 14;
        t = 51472 - t;
        s = (t * x) >>> 14;
        return quadrant[1] ? -s : s;
    endfunction

    function automatic logic [15:0] round_away(input longint prod, input int sh);
        longint mag, q;
        mag = prod < 0 ? -prod : prod;
        q = (mag + (longint'(1) << (sh - 1))) >>> sh;
        if (prod < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic longint clamp_count(input logic [8:0] c);
        if (c == 0) return 1;
        if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
        return c;
    endfunction

    function automatic longint sat_full(input longint v);
        return v > 65535 ? 65535 : v;
    endfunction

    task automatic predict_quad(input t_quad q);
        longint si, sj, ns, nl, r, red, green, blue, num, sp, cp, st, ct;
        logic [15:0] ph[2], th[2];
        t_vertex v;
        si = q.stack_idx;
        sj = q.slice_idx;
        ns = clamp_count(sh_stacks);
        nl = clamp_count(sh_slices);
        r = sh_radius;
        ph[0] = 16'((si * 65536 + ns) / (2 * ns));
        ph[1] = 16'(((si + 1) * 65536 + ns) / (2 * ns));
        th[0] = 16'((sj * 131072 + nl) / (2 * nl));
        th[1] = 16'(((sj + 1) * 131072 + nl) / (2 * nl));
        num = 65536 * (4 * si + ns);
        red = sat_full((2 * num + 5 * ns) / (10 * ns));
        if (3 * sj >= 5 * nl) green = 0;
        else begin
            num = 65536 * (5 * nl - 3 * sj);
            green = sat_full((2 * num + 5 * nl) / (10 * nl));
        end
        num = 65536 * (5 * sj + 2 * nl);
        blue = sat_full((2 * num + 10 * nl) / (20 * nl));
        for (int k = 0; k < 6; k++) begin
            sp = sin_q15(ph[CORNER_PHI[k]]);
            cp = sin_q15(ph[CORNER_PHI[k]] + 16'd16384);
            st = sin_q15(th[CORNER_TH[k]]);
            ct = sin_q15(th[CORNER_TH[k]] + 16'd16384);
            v.x = round_away(r * sp * ct, 30);
            v.y = round_away(r * cp, 15);
            v.z = round_away(r * sp * st, 30);
            v.red = red[15:0];
            v.green = green[15:0];
            v.blue = blue[15:0];
            v.corner = 3'(k);
            v.last = (k == CORNER_LAST);
            vertex_q.push_back(v);
        end
    endtask

    // driver: predict at acceptance so config in force is used
    always @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            predict_quad(t_quad'({s_tdata[7:0], s_tdata[15:8]}));
            void'(quad_q.pop_front());
        end
        if (i_rst_n && quad_q.size() > 0 && (!s_tvalid || s_tready)) begin
            if ($urandom_range(99) >= send_idle) begin
                t_quad nq;
                nq = quad_q[0];
                s_tvalid <= 1'b1;
                s_tdata <= {nq.slice_idx, nq.stack_idx};
            end else begin
                s_tvalid <= 1'b0;
            end
        end else if (s_tvalid && s_tready) begin
            s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (m_tvalid && m_tready) begin
            if (vertex_q.size() == 0) report_mismatch("vertex beat with none expected");
            else begin
                t_vertex e;
                e = vertex_q.pop_front();
                if (m_tdata[15:0] !== e.x)
                    report_mismatch($sformatf("x %h exp %h", m_tdata[15:0], e.x));
                if (m_tdata[31:16] !== e.y)
                    report_mismatch($sformatf("y %h exp %h", m_tdata[31:16], e.y));
                if (m_tdata[47:32] !== e.z)
                    report_mismatch($sformatf("z %h exp %h", m_tdata[47:32], e.z));
                if (m_tdata[63:48] !== e.red)
                    report_mismatch($sformatf("red %h exp %h", m_tdata[63:48], e.red));
                if (m_tdata[79:64] !== e.green)
                    report_mismatch($sformatf("green %h exp %h", m_tdata[79:64], e.green));
                if (m_tdata[95:80] !== e.blue)
                    report_mismatch($sformatf("blue %h exp %h", m_tdata[95:80], e.blue));
                if (m_tuser !== e.corner)
                    report_mismatch($sformatf("corner %0d exp %0d", m_tuser, e.corner));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last %b exp %b", m_tlast, e.last));
            end
        end
        m_tready <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RADIUS: sh_radius = val[14:0];
            REG_STACKS: sh_stacks = val[8:0];
            default:    sh_slices = val[8:0];
        endcase
    endtask

    task automatic drain;
        while (quad_q.size() > 0 || s_tvalid || vertex_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push_random(input int n, input int top_s, input int top_l);
        t_quad q;
        for (int k = 0; k < n; k++) begin
            q.stack_idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(top_s));
            q.slice_idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(top_l));
            quad_q.push_back(q);
        end
    endtask

    initial begin
        t_quad q;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: reset settings, poles, extremes, wrap past counts
        q = '{8'd0, 8'd0};     quad_q.push_back(q);
        q = '{8'd15, 8'd15};   quad_q.push_back(q);
        q = '{8'd16, 8'd16};   quad_q.push_back(q);
        q = '{8'd255, 8'd255}; quad_q.push_back(q);
        q = '{8'd170, 8'd85};  quad_q.push_back(q);
        q = '{8'd85, 8'd170};  quad_q.push_back(q);
        q = '{8'd7, 8'd27};    quad_q.push_back(q);
        drain();
        write_reg(REG_RADIUS, 32'd32767);
        write_reg(REG_STACKS, 32'd256);
        write_reg(REG_SLICES, 32'd256);
        q = '{8'd0, 8'd0};     quad_q.push_back(q);
        q = '{8'd255, 8'd255}; quad_q.push_back(q);
        q = '{8'd128, 8'd64};  quad_q.push_back(q);
        drain();
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_STACKS, 32'd0);
        write_reg(REG_SLICES, 32'd511);
        q = '{8'd0, 8'd1};     quad_q.push_back(q);
        q = '{8'd3, 8'd255};   quad_q.push_back(q);
        drain();
        write_reg(REG_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_STACKS, 32'd1);
        write_reg(REG_SLICES, 32'd300);
        q = '{8'd0, 8'd0};     quad_q.push_back(q);
        q = '{8'd1, 8'd200};   quad_q.push_back(q);
        drain();
        // random phases across settings and idle profiles
        for (int ph = 0; ph < 6; ph++) begin
            int s, l;
            if (ph == 2) begin send_idle = 88; recv_idle = 34; end
            if (ph == 4) begin send_idle = 0; recv_idle = 0; end
            s = $urandom_range(1, 40);
            l = $urandom_range(1, 40);
            write_reg(REG_RADIUS, $urandom_range(32767));
            write_reg(REG_STACKS, s);
            write_reg(REG_SLICES, l);
            push_random(35, s, l);
            drain();
        end
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
